// ----- sv/btb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_pkg
// Shared types and constants for the branch target buffer: operation codes,
// field widths and the request and response structures.
// ----------------------------------------------------------------------------
package btb_pkg;

  localparam int PC_W  = 64;
  localparam int CAP_W = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // Operation codes carried in the func field.
  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [PC_W-1:0]   branch_pc;
    logic [PC_W-1:0]   target_pc;
  } req_t;

  typedef struct packed {
    logic [PC_W-1:0]   predicted_target;
    logic              ok;
  } rsp_t;

endpackage

// ----- sv/branch_target_buffer_unit.sv -----
`timescale 1ns / 1ps
// Flow: a request is held in the input register, and the table logic forms
// its response into the result register once that register has room.
// Throughput: one operation per cycle while the result side is not stalled,
// set by the parallel compare and update of the table.
// Reset: valid bits and occupancy clear at once, capacity returns to 32;
// keys and targets are not cleared and there is no clearing pass.
// ----------------------------------------------------------------------------
// branch_target_buffer_unit
// Fully associative branch target buffer with lookup, insert and remove
// operations and a configurable capacity limit.
// ----------------------------------------------------------------------------
module branch_target_buffer_unit
  import btb_pkg::*;
#(
  parameter int ENTRIES = 32
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_func,
  input  logic [PC_W-1:0]  in_branch_pc,
  input  logic [PC_W-1:0]  in_target_pc,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PC_W-1:0]  out_predicted_target,
  output logic             out_ok,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  logic [CAP_W-1:0] capacity_r;
  req_t             in_req;
  req_t             req_r;
  rsp_t             rsp;
  rsp_t             rsp_r;
  logic             out_ready;
  logic             fire;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  assign in_req.func      = func_t'(in_func);
  assign in_req.branch_pc = in_branch_pc;
  assign in_req.target_pc = in_target_pc;

  btb_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_ready (out_ready),
    .fire      (fire),
    .req_r     (req_r)
  );

  btb_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .req      (req_r),
    .capacity (capacity_r),
    .rsp      (rsp)
  );

  btb_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .rsp       (rsp),
    .out_stall (out_stall),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .rsp_r     (rsp_r)
  );

  assign out_predicted_target = rsp_r.predicted_target;
  assign out_ok               = rsp_r.ok;

endmodule

// ----- sv/btb_in_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_in_reg
// Input register. Holds one accepted request until the table has processed
// it and the result register has room for its response.
// ----------------------------------------------------------------------------
module btb_in_reg
  import btb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_req,
  input  logic out_ready,
  output logic fire,
  output req_t req_r
);

  logic req_valid_r;
  logic req_valid_nxt;
  logic load;

  // The held request moves on whenever the result register can take it.
  assign fire     = req_valid_r && out_ready;
  assign in_stall = req_valid_r && !out_ready;
  assign load     = in_valid && !in_stall;

  // Occupancy of the input register.
  always_comb begin
    req_valid_nxt = req_valid_r;
    if (load) begin
      req_valid_nxt = 1'b1;
    end else if (fire) begin
      req_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
    end
  end

  // Payload is captured on every transfer; it needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= in_req;
    end
  end

endmodule

// ----- sv/btb_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_table
// Fully associative table of branch and target addresses. Compares the key
// against every valid entry in parallel, forms the response and applies the
// insert or remove in the same cycle.
// ----------------------------------------------------------------------------
module btb_table
  import btb_pkg::*;
#(
  parameter int ENTRIES = 32
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  req_t             req,
  input  logic [CAP_W-1:0] capacity,
  output rsp_t             rsp
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;
  logic [PC_W-1:0]    key_r [ENTRIES];
  logic [PC_W-1:0]    tgt_r [ENTRIES];
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] free_oh;
  logic [PC_W-1:0]    hit_target;
  logic               any_hit;
  logic               any_free;
  logic               below_cap;
  logic               do_insert;
  logic               do_remove;

  // Parallel key compare; keys are unique among valid entries.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == req.branch_pc);
    end
  end

  assign any_hit = |hit_vec;

  // One-hot select of the matching target.
  always_comb begin
    hit_target = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_target = hit_target | tgt_r[i];
      end
    end
  end

  // Lowest free entry as a one-hot vector.
  assign free_oh  = ~valid_r & (valid_r + ENTRIES'(1));
  assign any_free = ~&valid_r;

  assign below_cap = CMP_W'(count_r) < CMP_W'(capacity);
  assign do_insert = fire && (req.func == FUNC_INSERT) && below_cap && !any_hit && any_free;
  assign do_remove = fire && (req.func == FUNC_REMOVE) && any_hit;

  // Response for the current request.
  always_comb begin
    rsp.predicted_target = '0;
    rsp.ok               = 1'b0;
    case (req.func)
      FUNC_LOOKUP: begin
        rsp.ok = any_hit;
        if (any_hit) begin
          rsp.predicted_target = hit_target;
        end
      end
      FUNC_INSERT: begin
        rsp.ok = below_cap && (any_hit || any_free);
      end
      FUNC_REMOVE: begin
        rsp.ok = any_hit;
      end
      default: begin
        rsp.ok = 1'b0;
      end
    endcase
  end

  // Valid bits and occupancy count.
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (do_insert) begin
      valid_nxt = valid_r | free_oh;
      count_nxt = count_r + CNT_W'(1);
    end else if (do_remove) begin
      valid_nxt = valid_r & ~hit_vec;
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  // Key and target storage, written only on a successful insert.
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_insert && free_oh[i]) begin
        key_r[i] <= req.branch_pc;
        tgt_r[i] <= req.target_pc;
      end
    end
  end

endmodule

// ----- sv/btb_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_out_reg
// Result register. Holds one response until the downstream side takes it.
// ----------------------------------------------------------------------------
module btb_out_reg
  import btb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  rsp_t rsp,
  input  logic out_stall,
  output logic out_ready,
  output logic out_valid,
  output rsp_t rsp_r
);

  logic out_valid_r;
  logic out_valid_nxt;

  // Room for a new response when empty or when the held one transfers now.
  assign out_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_r <= rsp;
    end
  end

endmodule

// ----- sv/btb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_checker
// Port-level checks for the branch target buffer, attached to the top level.
// ----------------------------------------------------------------------------
module btb_checker
  import btb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_stall,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [PC_W-1:0]  out_predicted_target,
  input  logic             out_ok
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_predicted_target) && $stable(out_ok))
    else $error("stalled result changed");

  // A failed operation returns a zero target.
  a_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_predicted_target == '0)
    else $error("non-zero target on a failed operation");

  // With the result register empty the input side never stalls.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind branch_target_buffer_unit btb_checker u_btb_checker (.*);
